@@ hw/rtl/rstt_pkg.sv @@
// Shared types and constants for the reject sample tracking table.
// No dependencies; used by every module of the block but rstt_ram.
`timescale 1ns / 1ps
package rstt_pkg;

    localparam int POS_MAX_BITS = 64;   // widest encoder position a word may carry
    localparam int DELAY_BITS   = 24;
    localparam int COUNT_BITS   = 32;
    localparam int STAMP_BITS   = 32;
    localparam int CFG_IDX_BITS = 3;

    // func codes of an input word
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_TRIG1  = 2'd1;
    localparam logic [1:0] FUNC_TRIG2  = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    // station codes
    localparam logic [1:0] STN_NONE = 2'd0;
    localparam logic [1:0] STN_ONE  = 2'd1;
    localparam logic [1:0] STN_TWO  = 2'd2;

    // classified operations handed from front to back
    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_INS   = 3'd1;
    localparam logic [2:0] OP_TRIG1 = 3'd2;
    localparam logic [2:0] OP_TRIG2 = 3'd3;
    localparam logic [2:0] OP_CLR   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT_MODE_OFF = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SECOND_CAM_ON  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CAM1_KICK1     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CAM1_CAM2      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KICK1_PASS     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PASS_KICK2     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_SPAN    = 3'd6;

    typedef struct packed {
        logic [2:0]              op;
        logic                    station;   // 0: list 1, 1: list 2
        logic [COUNT_BITS-1:0]   count;
        logic [POS_MAX_BITS-1:0] pos;
    } t_cmd;

    typedef struct packed {
        logic                  count_mode_off;
        logic                  second_camera_on;
        logic [DELAY_BITS-1:0] cam1_to_kick1;
        logic [DELAY_BITS-1:0] cam1_to_cam2;
        logic [DELAY_BITS-1:0] kick1_to_pass;
        logic [DELAY_BITS-1:0] pass_to_kick2;
        logic [DELAY_BITS-1:0] sample_span;
    } t_cfg;

endpackage

@@ hw/rtl/rstt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rstt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/rstt_front.sv @@
// Front end: accepts input words, classifies them and queues them for the back end.
// Depends on rstt_pkg.
`timescale 1ns / 1ps
module rstt_front #(
    parameter int POSITION_BITS = 48
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_func,
    input  logic [1:0]                      i_station,
    input  logic [rstt_pkg::COUNT_BITS-1:0] i_count,
    input  logic [POSITION_BITS-1:0]        i_pos,
    output logic                            o_cmd_valid,
    output rstt_pkg::t_cmd                  o_cmd,
    input  logic                            i_cmd_pop
);
    rstt_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    rstt_pkg::t_cmd w_cmd;
    logic           w_push;

    always_comb begin
        // triggers take their list from func; only inserts use the station field
        w_cmd.station = (i_func == rstt_pkg::FUNC_TRIG2) ||
                        (i_func == rstt_pkg::FUNC_INSERT && i_station == rstt_pkg::STN_TWO);
        w_cmd.count   = i_count;
        w_cmd.pos     = rstt_pkg::POS_MAX_BITS'(i_pos);
        case (i_func)
            rstt_pkg::FUNC_INSERT: begin
                w_cmd.op = (i_station == rstt_pkg::STN_ONE || i_station == rstt_pkg::STN_TWO)
                         ? rstt_pkg::OP_INS : rstt_pkg::OP_NOP;
            end
            rstt_pkg::FUNC_TRIG1: w_cmd.op = rstt_pkg::OP_TRIG1;
            rstt_pkg::FUNC_TRIG2: w_cmd.op = rstt_pkg::OP_TRIG2;
            default:              w_cmd.op = rstt_pkg::OP_CLR;
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_cmd_pop);
        end
    end
endmodule

@@ hw/rtl/rstt_back.sv @@
// Back end: walks the entry store for inserts and triggers, holds the result register.
// Depends on rstt_pkg and rstt_ram.
`timescale 1ns / 1ps
module rstt_back #(
    parameter int STORE_DEPTH   = 128,
    parameter int POSITION_BITS = 48
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rstt_pkg::t_cfg i_cfg,
    input  logic           i_cmd_valid,
    input  rstt_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_reject,
    output logic [1:0]     o_kick_station
);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int P  = POSITION_BITS;
    localparam int CB = rstt_pkg::COUNT_BITS;
    localparam int SB = rstt_pkg::STAMP_BITS;
    localparam int RW = 1 + CB + P + SB;
    localparam logic [AW:0] LAST = (AW+1)'(STORE_DEPTH - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FIND  = 3'd1;
    localparam logic [2:0] ST_PREP  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]             r_state;
    rstt_pkg::t_cmd         r_cmd;
    logic [STORE_DEPTH-1:0] r_valid;
    logic [AW:0]            r_idx;
    logic [SB-1:0]          r_stamp;
    logic [CB-1:0]          r_tcnt;
    logic [P-1:0]           r_trig_off;
    logic                   r_a_vld, r_b_vld;
    logic [AW-1:0]          r_a_idx, r_b_idx, r_best_idx;
    logic [SB-1:0]          r_b_age, r_best_age;
    logic                   r_best_found;
    logic                   r_out_vld, r_out_rej;
    logic [1:0]             r_out_stn;

    logic          w_we;
    logic [RW-1:0] w_wdata, w_rdata;
    logic [P-1:0]  w_d1, w_off, w_diff, w_mag, w_pos;
    logic          w_e_stn, w_hit;
    logic [CB-1:0] w_e_cnt;
    logic [SB-1:0] w_e_stamp;
    logic [63:0]   w_win;

    assign w_we    = (r_state == ST_FIND) && !r_valid[r_idx[AW-1:0]];
    assign w_wdata = {r_cmd.station, r_cmd.count, r_cmd.pos[P-1:0], r_stamp};

    rstt_ram #(.WIDTH(RW), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // station offsets, modulo 2^P
    always_comb begin
        w_d1 = i_cfg.second_camera_on
             ? P'(64'(i_cfg.cam1_to_kick1) - 64'(i_cfg.cam1_to_cam2))
             : P'(64'(i_cfg.cam1_to_kick1));
        w_off = (r_cmd.op == rstt_pkg::OP_TRIG2)
              ? w_d1 + P'(64'(i_cfg.kick1_to_pass)) + P'(64'(i_cfg.pass_to_kick2))
              : w_d1;
    end

    // per-entry match
    always_comb begin
        {w_e_stn, w_e_cnt, w_pos, w_e_stamp} = w_rdata;
        w_diff = r_trig_off - w_pos;
        w_mag  = w_diff[P-1] ? (P'(0) - w_diff) : w_diff;
        w_win  = 64'(i_cfg.sample_span >> 1);
        if (r_cmd.op == rstt_pkg::OP_TRIG1 && !i_cfg.count_mode_off) begin
            w_hit = (w_e_cnt == r_tcnt);
        end else begin
            w_hit = (64'(w_mag) <= w_win);
        end
    end

    assign o_cmd_pop      = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_valid        = r_out_vld;
    assign o_reject       = r_out_rej;
    assign o_kick_station = r_out_stn;

    always_ff @(posedge i_clk) begin
        r_cmd      <= o_cmd_pop ? i_cmd : r_cmd;
        r_a_idx    <= r_idx[AW-1:0];
        r_b_idx    <= r_a_idx;
        r_b_age    <= r_stamp - w_e_stamp;
        if (r_state == ST_PREP) begin
            r_trig_off <= r_cmd.pos[P-1:0] - w_off;
        end
        if (r_b_vld && (!r_best_found || r_b_age > r_best_age)) begin
            r_best_idx <= r_b_idx;
            r_best_age <= r_b_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid      <= '0;
            r_idx        <= '0;
            r_stamp      <= '0;
            r_tcnt       <= '0;
            r_a_vld      <= 1'b0;
            r_b_vld      <= 1'b0;
            r_best_found <= 1'b0;
            r_out_vld    <= 1'b0;
            r_out_rej    <= 1'b0;
            r_out_stn    <= rstt_pkg::STN_ONE;
        end else begin
            r_a_vld <= (r_state == ST_SCAN);
            r_b_vld <= r_a_vld && r_valid[r_a_idx] && (w_e_stn == r_cmd.station) && w_hit;
            if (r_b_vld) r_best_found <= 1'b1;
            if (r_out_vld && i_ready && r_state != ST_OUT) r_out_vld <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_idx <= '0;
                    if (i_cmd_valid) begin
                        case (i_cmd.op)
                            rstt_pkg::OP_INS:   r_state <= ST_FIND;
                            rstt_pkg::OP_CLR:   r_valid <= '0;
                            rstt_pkg::OP_TRIG1: begin
                                r_tcnt  <= r_tcnt + CB'(1);
                                r_state <= ST_PREP;
                            end
                            rstt_pkg::OP_TRIG2: r_state <= ST_PREP;
                            default: ;
                        endcase
                    end
                end
                ST_FIND: begin
                    if (w_we) begin
                        r_valid[r_idx[AW-1:0]] <= 1'b1;
                        r_stamp <= r_stamp + SB'(1);
                        r_state <= ST_IDLE;
                    end else if (r_idx == LAST) begin
                        r_state <= ST_IDLE;   // store full, drop
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_PREP: begin
                    r_best_found <= 1'b0;
                    r_state      <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (r_idx == LAST) r_state <= ST_DRAIN;
                    else               r_idx   <= r_idx + 1'b1;
                end
                ST_DRAIN: begin
                    if (!r_a_vld && !r_b_vld) begin
                        if (r_best_found) r_valid[r_best_idx] <= 1'b0;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_out_vld || i_ready) begin
                        r_out_vld <= 1'b1;
                        r_out_rej <= r_best_found;
                        r_out_stn <= r_cmd.station ? rstt_pkg::STN_TWO : rstt_pkg::STN_ONE;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

@@ hw/rtl/reject_sample_tracking_table.sv @@
// Top level of the reject sample tracking table: config registers, front and back end.
// Depends on rstt_pkg, rstt_front, rstt_back (and rstt_ram through rstt_back).
`timescale 1ns / 1ps
// Keeps one shared store of STORE_DEPTH inspected samples for two reject
// stations. An insert word lands in the lowest free slot (one slot checked per
// cycle); a trigger word walks every slot of the store through the RAM read
// port, one slot per cycle, and then loads its result word into the result
// register; a clear or an ignored insert is handled in the idle state. The
// slot walk through the single store read port sets the rate. A two-word queue
// sits in front, and the result register lets the next word start while a
// result waits. Triggers give one result word each; inserts and clears give
// none. Write configuration only while idle.
module reject_sample_tracking_table #(
    parameter int STORE_DEPTH   = 128,
    parameter int POSITION_BITS = 48
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // input words
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [31:0] sample_count, [32 +: POSITION_BITS] encoder_position
    input  logic [((32+POSITION_BITS+7)/8)*8-1:0]   i_s_axis_tdata,
    // [1:0] func, [3:2] station
    input  logic [3:0]                              i_s_axis_tuser,
    // result words
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // [0] reject, rest zero
    output logic [7:0]                              o_m_axis_tdata,
    // [1:0] kick_station
    output logic [1:0]                              o_m_axis_tuser,
    // configuration writes
    input  logic                                    i_cfg_we,
    input  logic [rstt_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [rstt_pkg::DELAY_BITS-1:0]         i_cfg_data
);
    rstt_pkg::t_cfg r_cfg;
    rstt_pkg::t_cmd w_cmd;
    logic           w_cmd_valid, w_cmd_pop, w_reject;

    // configuration registers, each masked to its width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rstt_pkg::CFG_COUNT_MODE_OFF: r_cfg.count_mode_off   <= i_cfg_data[0];
                rstt_pkg::CFG_SECOND_CAM_ON:  r_cfg.second_camera_on <= i_cfg_data[0];
                rstt_pkg::CFG_CAM1_KICK1:     r_cfg.cam1_to_kick1    <= i_cfg_data;
                rstt_pkg::CFG_CAM1_CAM2:      r_cfg.cam1_to_cam2     <= i_cfg_data;
                rstt_pkg::CFG_KICK1_PASS:     r_cfg.kick1_to_pass    <= i_cfg_data;
                rstt_pkg::CFG_PASS_KICK2:     r_cfg.pass_to_kick2    <= i_cfg_data;
                rstt_pkg::CFG_SAMPLE_SPAN:    r_cfg.sample_span      <= i_cfg_data;
                default: ;  // out-of-range index: no effect
            endcase
        end
    end

    // front: accept and classify, queue
    rstt_front #(.POSITION_BITS(POSITION_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_func      (i_s_axis_tuser[1:0]),
        .i_station   (i_s_axis_tuser[3:2]),
        .i_count     (i_s_axis_tdata[31:0]),
        .i_pos       (i_s_axis_tdata[32 +: POSITION_BITS]),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // back: store walk and result register
    rstt_back #(.STORE_DEPTH(STORE_DEPTH), .POSITION_BITS(POSITION_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .o_cmd_pop      (w_cmd_pop),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_reject       (w_reject),
        .o_kick_station (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {7'd0, w_reject};
endmodule

@@ sim/tb.sv @@
// Self-checking testbench for reject_sample_tracking_table.
// Depends on rstt_pkg and the block RTL; a built-in predictor checks every result word.
`timescale 1ns / 1ps
module tb;

    localparam int DEPTH    = 128;
    localparam int PBITS    = 48;
    localparam int DW       = ((32 + PBITS + 7) / 8) * 8;
    localparam int LIMIT    = 2_000_000;
    localparam int SETTLE   = 600;    // longer than finishing a full queue of inserts
    localparam logic [rstt_pkg::CFG_IDX_BITS-1:0] CFG_IDX_UNUSED = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [DW-1:0] s_data = '0;
    logic [3:0] s_user = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_data;
    logic [1:0] m_user;
    logic cfg_we = 1'b0;
    logic [rstt_pkg::CFG_IDX_BITS-1:0] cfg_idx = '0;
    logic [rstt_pkg::DELAY_BITS-1:0] cfg_data = '0;

    reject_sample_tracking_table #(.STORE_DEPTH(DEPTH), .POSITION_BITS(PBITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // predictor state: config shadow and table copy
    rstt_pkg::t_cfg cfg_shadow;
    bit        tbl_valid [DEPTH];
    bit        tbl_stn   [DEPTH];
    bit [31:0] tbl_count [DEPTH];
    bit [PBITS-1:0] tbl_pos [DEPTH];
    bit [31:0] tbl_age   [DEPTH];
    bit [31:0] age_ctr;
    bit [31:0] trig_ctr;

    typedef struct packed {
        logic       reject;
        logic [1:0] stn;
    } t_verdict;
    t_verdict pending_verdicts[$];

    int  fail_cnt = 0;
    longint cycle = 0;
    bit  idle_off = 1'b0;    // no stalls in the closing stretch
    int  stall_left = 0;     // remaining cycles of a receiver stall burst

    task automatic report(input string what);
        $display("MISMATCH: %s", what);
        fail_cnt++;
    endtask

    function automatic bit in_window(bit [PBITS-1:0] trig, bit [PBITS-1:0] pos,
                                     bit [PBITS-1:0] ofs);
        bit [PBITS-1:0] d;
        bit [PBITS-1:0] mag;
        d = trig - pos - ofs;
        mag = d[PBITS-1] ? -d : d;
        return mag <= (cfg_shadow.sample_span >> 1);
    endfunction

    // oldest matching entry of one list is removed; returns reject bit
    function automatic bit kick_search(bit stn, bit by_count, bit [PBITS-1:0] trig,
                                       bit [PBITS-1:0] ofs);
        int best;
        bit [31:0] best_age;
        bit hit;
        best = -1;
        best_age = 0;
        for (int i = 0; i < DEPTH; i++) begin
            if (!tbl_valid[i] || tbl_stn[i] != stn) continue;
            hit = by_count ? (tbl_count[i] == trig_ctr) : in_window(trig, tbl_pos[i], ofs);
            if (!hit) continue;
            if (best < 0 || (age_ctr - tbl_age[i]) > best_age) begin
                best = i;
                best_age = age_ctr - tbl_age[i];
            end
        end
        if (best < 0) return 1'b0;
        tbl_valid[best] = 1'b0;
        return 1'b1;
    endfunction

    task automatic predict_word(bit [1:0] fn, bit [1:0] stn, bit [31:0] cnt,
                                bit [PBITS-1:0] pos);
        bit [PBITS-1:0] d1;
        bit [PBITS-1:0] d2;
        t_verdict v;
        d1 = cfg_shadow.second_camera_on ?
             PBITS'(cfg_shadow.cam1_to_kick1) - PBITS'(cfg_shadow.cam1_to_cam2) :
             PBITS'(cfg_shadow.cam1_to_kick1);
        d2 = d1 + PBITS'(cfg_shadow.kick1_to_pass) + PBITS'(cfg_shadow.pass_to_kick2);
        case (fn)
            rstt_pkg::FUNC_INSERT: begin
                if (stn == rstt_pkg::STN_ONE || stn == rstt_pkg::STN_TWO) begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (!tbl_valid[i]) begin
                            tbl_valid[i] = 1'b1;
                            tbl_stn[i]   = (stn == rstt_pkg::STN_TWO);
                            tbl_count[i] = cnt;
                            tbl_pos[i]   = pos;
                            tbl_age[i]   = age_ctr;
                            age_ctr++;
                            break;
                        end
                    end
                end
            end
            rstt_pkg::FUNC_CLEAR: begin
                foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
            end
            rstt_pkg::FUNC_TRIG1: begin
                trig_ctr++;
                v.reject = kick_search(1'b0, !cfg_shadow.count_mode_off, pos, d1);
                v.stn = rstt_pkg::STN_ONE;
                pending_verdicts.push_back(v);
            end
            default: begin
                v.reject = kick_search(1'b1, 1'b0, pos, d2);
                v.stn = rstt_pkg::STN_TWO;
                pending_verdicts.push_back(v);
            end
        endcase
    endtask

    // send one word, with optional random gap before it; valid stays up afterwards
    task automatic send_word(bit [1:0] fn, bit [1:0] stn, bit [31:0] cnt,
                             bit [PBITS-1:0] pos);
        int gap;
        if (!idle_off && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_user  <= {stn, fn};
        s_data  <= DW'({pos, cnt});
        s_valid <= 1'b1;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        predict_word(fn, stn, cnt, pos);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [rstt_pkg::CFG_IDX_BITS-1:0] idx,
                             bit [rstt_pkg::DELAY_BITS-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            rstt_pkg::CFG_COUNT_MODE_OFF: cfg_shadow.count_mode_off   = val[0];
            rstt_pkg::CFG_SECOND_CAM_ON:  cfg_shadow.second_camera_on = val[0];
            rstt_pkg::CFG_CAM1_KICK1:     cfg_shadow.cam1_to_kick1    = val;
            rstt_pkg::CFG_CAM1_CAM2:      cfg_shadow.cam1_to_cam2     = val;
            rstt_pkg::CFG_KICK1_PASS:     cfg_shadow.kick1_to_pass    = val;
            rstt_pkg::CFG_PASS_KICK2:     cfg_shadow.pass_to_kick2    = val;
            rstt_pkg::CFG_SAMPLE_SPAN:    cfg_shadow.sample_span      = val;
            default: ;
        endcase
    endtask

    task automatic set_config(bit mode_off, bit cam2, bit [23:0] k1, bit [23:0] c2,
                              bit [23:0] kp, bit [23:0] pk, bit [23:0] span);
        write_reg(rstt_pkg::CFG_COUNT_MODE_OFF, 24'(mode_off));
        write_reg(rstt_pkg::CFG_SECOND_CAM_ON, 24'(cam2));
        write_reg(rstt_pkg::CFG_CAM1_KICK1, k1);
        write_reg(rstt_pkg::CFG_CAM1_CAM2, c2);
        write_reg(rstt_pkg::CFG_KICK1_PASS, kp);
        write_reg(rstt_pkg::CFG_PASS_KICK2, pk);
        write_reg(rstt_pkg::CFG_SAMPLE_SPAN, span);
    endtask

    // count mode: inserts with counts tied to the trigger counter, extremes of fields
    task automatic test_count_directed();
        send_word(rstt_pkg::FUNC_INSERT, rstt_pkg::STN_ONE, trig_ctr + 1, '1);
        send_word(rstt_pkg::FUNC_INSERT, rstt_pkg::STN_ONE, trig_ctr + 1, '0); // younger
        send_word(rstt_pkg::FUNC_INSERT, rstt_pkg::STN_ONE, 32'hFFFF_FFFF,
                  48'h8000_0000_0000);
        send_word(rstt_pkg::FUNC_INSERT, rstt_pkg::STN_NONE, trig_ctr + 2, '0); // ignored
        send_word(rstt_pkg::FUNC_INSERT, 2'd3, trig_ctr + 2, '0);              // ignored
        send_word(rstt_pkg::FUNC_TRIG1, 2'd3, '1, '1);                         // hits oldest
        send_word(rstt_pkg::FUNC_TRIG1, rstt_pkg::STN_NONE, '0, '0);           // miss
        send_word(rstt_pkg::FUNC_INSERT, rstt_pkg::STN_TWO, 32'h5555_AAAA,
                  48'h0000_0000_0010);
        send_word(rstt_pkg::FUNC_TRIG2, rstt_pkg::STN_ONE, '0,
                  48'h0000_0000_0010);                                         // exact hit
        send_word(rstt_pkg::FUNC_TRIG2, rstt_pkg::STN_TWO, '0,
                  48'h0000_0000_0010);                                         // now empty
        send_word(rstt_pkg::FUNC_CLEAR, rstt_pkg::STN_TWO, '1, '1);
        send_word(rstt_pkg::FUNC_TRIG1, rstt_pkg::STN_ONE, '0, '0);
    endtask

    // fill the store past full, then clear
    task automatic test_store_full();
        for (int i = 0; i < DEPTH + 3; i++)
            send_word(rstt_pkg::FUNC_INSERT, (i % 2) ? rstt_pkg::STN_TWO : rstt_pkg::STN_ONE,
                      $urandom, PBITS'(i * 4));
        send_word(rstt_pkg::FUNC_TRIG2, rstt_pkg::STN_NONE, '0, 48'd5);
        send_word(rstt_pkg::FUNC_INSERT, rstt_pkg::STN_ONE, $urandom, 48'd9); // dropped unless the trigger freed a slot
        send_word(rstt_pkg::FUNC_INSERT, rstt_pkg::STN_ONE, $urandom, 48'd9); // dropped
        send_word(rstt_pkg::FUNC_CLEAR, rstt_pkg::STN_NONE, '0, '0);
        send_word(rstt_pkg::FUNC_TRIG1, rstt_pkg::STN_ONE, '0, 48'd9);
    endtask

    // encoder windows around wrap and the sign boundary
    task automatic test_window_edges();
        bit [PBITS-1:0] base;
        base = 48'hFFFF_FFFF_FFF0;
        send_word(rstt_pkg::FUNC_INSERT, rstt_pkg::STN_ONE, '0, base);
        send_word(rstt_pkg::FUNC_INSERT, rstt_pkg::STN_ONE, '0, base);
        // offset from config moves the target; edges of the half-span window
        send_word(rstt_pkg::FUNC_TRIG1, rstt_pkg::STN_ONE, '0, base + (cfg_shadow.cam1_to_kick1
                  - cfg_shadow.cam1_to_cam2) + (cfg_shadow.sample_span >> 1));
        send_word(rstt_pkg::FUNC_TRIG1, rstt_pkg::STN_ONE, '0, base + (cfg_shadow.cam1_to_kick1
                  - cfg_shadow.cam1_to_cam2) - (cfg_shadow.sample_span >> 1) - 1);
        send_word(rstt_pkg::FUNC_INSERT, rstt_pkg::STN_ONE, '0, 48'h8000_0000_0000);
        send_word(rstt_pkg::FUNC_TRIG1, rstt_pkg::STN_ONE, '0, '0);
    endtask

    // random traffic, mostly triggers, plus inserts that later triggers can find and rare clears
    task automatic test_random(int n_words);
        bit [PBITS-1:0] pos;
        bit [PBITS-1:0] ofs;
        bit [1:0] stn;
        int pick;
        for (int k = 0; k < n_words; k++) begin
            pick = $urandom_range(0, 99);
            stn = 2'($urandom_range(1, 2));
            pos = PBITS'({$urandom, $urandom});
            if (pick < 45) begin
                send_word(rstt_pkg::FUNC_INSERT, (pick < 2) ? 2'($urandom_range(0, 3)) : stn,
                          trig_ctr + $urandom_range(1, 6), pos);
            end else if (pick < 97) begin
                // aim near a live entry most of the time
                ofs = cfg_shadow.second_camera_on ?
                      PBITS'(cfg_shadow.cam1_to_kick1) - PBITS'(cfg_shadow.cam1_to_cam2) :
                      PBITS'(cfg_shadow.cam1_to_kick1);
                if (stn == rstt_pkg::STN_TWO)
                    ofs += PBITS'(cfg_shadow.kick1_to_pass) + PBITS'(cfg_shadow.pass_to_kick2);
                for (int i = 0; i < DEPTH; i++) begin
                    if (tbl_valid[i] && tbl_stn[i] == (stn == rstt_pkg::STN_TWO) &&
                        $urandom_range(0, 3) != 0) begin
                        pos = tbl_pos[i] + ofs + PBITS'($signed($urandom_range(0, 40)) - 20);
                        break;
                    end
                end
                send_word((stn == rstt_pkg::STN_ONE) ? rstt_pkg::FUNC_TRIG1
                                                     : rstt_pkg::FUNC_TRIG2,
                          2'($urandom), $urandom, pos);
            end else begin
                send_word(rstt_pkg::FUNC_CLEAR, 2'($urandom), $urandom, pos);
            end
        end
    endtask

    // result checker and random receiver stall bursts
    always @(posedge i_clk) begin
        t_verdict want;
        cycle <= cycle + 1;
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                report("result word with none expected");
            end else begin
                want = pending_verdicts.pop_front();
                if (m_data[0] !== want.reject)
                    report($sformatf("reject got %b want %b", m_data[0], want.reject));
                if (m_data[7:1] !== 7'd0)
                    report($sformatf("tdata pad bits %h", m_data));
                if (m_user !== want.stn)
                    report($sformatf("kick_station got %0d want %0d", m_user, want.stn));
            end
        end
        if (idle_off) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        wait (cycle >= LIMIT);
        $display("timeout");
        $display("tb failed");
        $finish;
    end

    initial begin
        cfg_shadow = '0;
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        age_ctr = 0;
        trig_ctr = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_count_directed();
        drain();
        set_config(1'b1, 1'b0, 24'd100, 24'd0, 24'd50, 24'd25, 24'd20);
        test_window_edges();
        test_random(150);
        drain();
        set_config(1'b1, 1'b1, 24'd10, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        test_window_edges();
        test_random(150);
        drain();    // sender holds off until every result is in
        set_config(1'b0, 1'b1, 24'hFF_FFFF, 24'h00_0001, 24'd0, 24'd7, 24'd1);
        test_store_full();
        test_random(200);
        drain();
        set_config(1'b1, 1'b0, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                   24'd64);
        write_reg(CFG_IDX_UNUSED, '1);    // out-of-range index has no effect
        test_random(200);
        idle_off = 1'b1;
        test_random(80);
        drain();

        if (fail_cnt == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

@@ reject_sample_tracking_table.f @@
hw/rtl/rstt_pkg.sv
hw/rtl/rstt_ram.sv
hw/rtl/rstt_front.sv
hw/rtl/rstt_back.sv
hw/rtl/reject_sample_tracking_table.sv
sim/tb.sv
